// ===== rtl/sobthr_pkg.sv =====
// ----------------------------------------------------------------------------
// sobthr_pkg
// shared widths, register codes, reset values and pipeline types
// ----------------------------------------------------------------------------
package sobthr_pkg;

   localparam int PIXEL_W    = 8;
   localparam int THR_W      = 11;
   localparam int IMG_W_W    = 11;
   localparam int ROW_W      = 16;
   localparam int COL_OUT_W  = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam int COLSUM_W  = PIXEL_W + 2;
   localparam int COLDIFF_W = PIXEL_W + 1;
   localparam int GRAD_W    = PIXEL_W + 3;
   localparam int SQ_W      = 2 * PIXEL_W + 4;
   localparam int MAG_W     = SQ_W + 1;
   localparam int THR_SQ_W  = 2 * THR_W;

   localparam int MIN_DIM = 3;

   localparam logic [THR_W-1:0]   THR_RESET    = 11'd70;
   localparam logic [IMG_W_W-1:0] WIDTH_RESET  = 11'd1024;
   localparam logic [ROW_W-1:0]   HEIGHT_RESET = 16'd768;

   localparam logic [PIXEL_W-1:0] EDGE_ON  = 8'd255;
   localparam logic [PIXEL_W-1:0] EDGE_OFF = 8'd0;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_EDGE_THRESHOLD = 2'd0,
      REG_IMAGE_WIDTH    = 2'd1,
      REG_IMAGE_HEIGHT   = 2'd2
   } csr_reg_type;

   typedef logic [PIXEL_W-1:0] pixel_type;

   typedef struct packed {
      pixel_type top;
      pixel_type mid;
      pixel_type bot;
   } column_type;

   typedef struct packed {
      logic [ROW_W-1:0]     row;
      logic [COL_OUT_W-1:0] col;
      logic                 last;
   } meta_type;

endpackage

// ===== rtl/sobthr_if.sv =====
// ----------------------------------------------------------------------------
// sobthr interfaces
// pixel request, edge response and register write channels
// ----------------------------------------------------------------------------
interface sobthr_req_if import sobthr_pkg::*;;
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel_value;

   modport source (output valid, output pixel_value, input ready);
   modport sink   (input valid, input pixel_value, output ready);
endinterface

interface sobthr_rsp_if import sobthr_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [PIXEL_W-1:0]   edge_value;
   logic [ROW_W-1:0]     out_row;
   logic [COL_OUT_W-1:0] out_col;
   logic                 frame_last;

   modport source (output valid, output edge_value, output out_row, output out_col,
                   output frame_last, input ready);
   modport sink   (input valid, input edge_value, input out_row, input out_col,
                   input frame_last, output ready);
endinterface

interface sobthr_csr_if import sobthr_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/sobthr_col_cell.sv =====
// ----------------------------------------------------------------------------
// sobthr_col_cell
// one window column: holds three pixels, shifts to its neighbor, column sums
// ----------------------------------------------------------------------------
module sobthr_col_cell
   import sobthr_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        shift_en,
   input  column_type                  col_in,
   output column_type                  col_out,
   output logic [COLSUM_W-1:0]         col_sum,
   output logic signed [COLDIFF_W-1:0] col_diff
);

   column_type col_ff;
   column_type col_in_q;

   assign col_in_q = shift_en ? col_in : col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else begin
         col_ff <= col_in_q;
      end
   end

   assign col_out  = col_ff;
   // weights 1,2,1 down the column, and top minus bottom
   assign col_sum  = {2'b00, col_ff.top} + {1'b0, col_ff.mid, 1'b0} + {2'b00, col_ff.bot};
   assign col_diff = $signed({1'b0, col_ff.top}) - $signed({1'b0, col_ff.bot});

endmodule

// ===== rtl/sobthr_mag.sv =====
// ----------------------------------------------------------------------------
// sobthr_mag
// gradients, squared magnitude and threshold compare, three register stages
// ----------------------------------------------------------------------------
module sobthr_mag
   import sobthr_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        in_valid,
   input  meta_type                    in_meta,
   input  logic [COLSUM_W-1:0]         col_sum [3],
   input  logic signed [COLDIFF_W-1:0] col_diff [3],
   input  logic [THR_W-1:0]            threshold,
   output logic                        out_valid,
   output logic [PIXEL_W-1:0]          out_edge,
   output meta_type                    out_meta
);

   logic                       g_valid_ff;
   logic signed [GRAD_W-1:0]   gx_ff;
   logic signed [GRAD_W-1:0]   gy_ff;
   meta_type                   g_meta_ff;
   logic signed [GRAD_W-1:0]   gx_in;
   logic signed [GRAD_W-1:0]   gy_in;

   logic                       q_valid_ff;
   logic [SQ_W-1:0]            sqx_ff;
   logic [SQ_W-1:0]            sqy_ff;
   logic [THR_SQ_W-1:0]        thr_sq_ff;
   meta_type                   q_meta_ff;
   logic signed [2*GRAD_W-1:0] sqx_full;
   logic signed [2*GRAD_W-1:0] sqy_full;
   logic [THR_SQ_W-1:0]        thr_sq_in;

   logic                       o_valid_ff;
   logic [PIXEL_W-1:0]         edge_ff;
   meta_type                   o_meta_ff;
   logic [MAG_W-1:0]           mag_sum;
   logic [PIXEL_W-1:0]         edge_in;

   // left column minus right column, top row minus bottom row
   assign gx_in = $signed({1'b0, col_sum[0]}) - $signed({1'b0, col_sum[2]});
   assign gy_in = {{2{col_diff[0][COLDIFF_W-1]}}, col_diff[0]}
                + {col_diff[1][COLDIFF_W-1], col_diff[1], 1'b0}
                + {{2{col_diff[2][COLDIFF_W-1]}}, col_diff[2]};

   assign sqx_full  = gx_ff * gx_ff;
   assign sqy_full  = gy_ff * gy_ff;
   assign thr_sq_in = THR_SQ_W'(threshold) * THR_SQ_W'(threshold);

   assign mag_sum = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign edge_in = ({1'b0, mag_sum} > thr_sq_ff) ? EDGE_ON : EDGE_OFF;

   always_ff @(posedge clock) begin
      if (reset) begin
         g_valid_ff <= 1'b0;
         q_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else if (advance) begin
         g_valid_ff <= in_valid;
         q_valid_ff <= g_valid_ff;
         o_valid_ff <= q_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         gx_ff     <= gx_in;
         gy_ff     <= gy_in;
         g_meta_ff <= in_meta;
         sqx_ff    <= sqx_full[SQ_W-1:0];
         sqy_ff    <= sqy_full[SQ_W-1:0];
         thr_sq_ff <= thr_sq_in;
         q_meta_ff <= g_meta_ff;
         edge_ff   <= edge_in;
         o_meta_ff <= q_meta_ff;
      end
   end

   assign out_valid = o_valid_ff;
   assign out_edge  = edge_ff;
   assign out_meta  = o_meta_ff;

endmodule

// ===== rtl/sobel_edge_threshold_top.sv =====
// ----------------------------------------------------------------------------
// sobel_edge_threshold_top
// streaming 3x3 sobel edge detector with a squared-magnitude threshold
//
// req_bus carries 8-bit grayscale pixels in raster order, one per transfer.
// rsp_bus gives one result per interior pixel: 255 for an edge, 0 otherwise,
// with its row, column and a mark on the last interior pixel of the frame.
// border rows and columns give no result. csr_bus writes edge_threshold (0),
// image_width (1) and image_height (2); write them only while the block idles.
// throughput is one pixel per clock, set by one line store read and one line
// store write each cycle. a result passes stage 1, the window cells and the
// gradient, square and compare registers. when rsp_bus stalls the whole
// pipeline holds and req_bus.ready drops until the output register is taken.
// reset clears position counters, the window and all valids and loads the
// default registers (threshold 70, 1024 x 768); the line stores are not
// cleared, each entry that feeds a result is written a row before it is read.
// ----------------------------------------------------------------------------
module sobel_edge_threshold_top
   import sobthr_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  logic          clock,
   input  logic          reset,
   sobthr_req_if.sink    req_bus,
   sobthr_rsp_if.source  rsp_bus,
   sobthr_csr_if.sink    csr_bus
);

   localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int CMP_W = (COL_W + 1 > IMG_W_W) ? COL_W + 1 : IMG_W_W;
   localparam logic [CMP_W-1:0] MAX_W_C = CMP_W'(MAX_WIDTH);
   localparam logic [CMP_W-1:0] MIN_W_C = CMP_W'(MIN_DIM);
   localparam logic [ROW_W-1:0] MIN_H_C = ROW_W'(MIN_DIM);

   // configuration registers
   logic [THR_W-1:0]   thr_ff,    thr_in;
   logic [IMG_W_W-1:0] width_ff,  width_in;
   logic [ROW_W-1:0]   height_ff, height_in;
   logic               csr_write;

   // position counters
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   logic [CMP_W-1:0] width_ext;
   logic [CMP_W-1:0] eff_w;
   logic [ROW_W-1:0] eff_h;
   logic             col_wrap;
   logic [COL_W-1:0] cur_col;
   logic [CMP_W-1:0] cur_col_ext;
   logic [ROW_W-1:0] row_pre;
   logic [ROW_W-1:0] cur_row;
   logic [CMP_W-1:0] col_inc;
   logic [ROW_W-1:0] row_inc;
   logic             cur_emit;
   logic             cur_last;

   logic accept;
   logic advance;

   // stage 1: line store read
   logic               s1_valid_ff;
   logic [PIXEL_W-1:0] s1_pix_ff;
   logic [COL_W-1:0]   s1_col_ff;
   logic [ROW_W-1:0]   s1_row_ff;
   logic               s1_emit_ff;
   logic               s1_last_ff;
   logic [2*PIXEL_W-1:0] line_rd_ff;
   logic [2*PIXEL_W-1:0] line_mem [MAX_WIDTH];

   // stage 2: window
   logic     s2_valid_ff;
   meta_type s2_meta_ff;
   meta_type s2_meta_in;
   logic     shift_en;

   column_type                  col_chain [4];
   logic [COLSUM_W-1:0]         col_sum   [3];
   logic signed [COLDIFF_W-1:0] col_diff  [3];

   logic               mag_valid;
   logic [PIXEL_W-1:0] mag_edge;
   meta_type           mag_meta;

   // register writes
   assign csr_bus.ready = !reset;
   assign csr_write     = csr_bus.valid && csr_bus.ready;

   always_comb begin
      thr_in    = thr_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         unique case (csr_reg_type'(csr_bus.index))
            REG_EDGE_THRESHOLD: thr_in    = csr_bus.data[THR_W-1:0];
            REG_IMAGE_WIDTH:    width_in  = csr_bus.data[IMG_W_W-1:0];
            REG_IMAGE_HEIGHT:   height_in = csr_bus.data[ROW_W-1:0];
            default: begin
               thr_in = thr_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= THR_RESET;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else begin
         thr_ff    <= thr_in;
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // clamped frame geometry
   assign width_ext = CMP_W'(width_ff);
   assign eff_w     = (width_ext < MIN_W_C) ? MIN_W_C :
                      (width_ext > MAX_W_C) ? MAX_W_C : width_ext;
   assign eff_h     = (height_ff < MIN_H_C) ? MIN_H_C : height_ff;

   // position of the incoming pixel
   assign col_wrap    = CMP_W'(col_ff) >= eff_w;
   assign cur_col     = col_wrap ? '0 : col_ff;
   assign cur_col_ext = CMP_W'(cur_col);
   assign row_pre     = col_wrap ? row_ff + 16'd1 : row_ff;
   assign cur_row     = (row_pre >= eff_h) ? '0 : row_pre;
   assign col_inc     = cur_col_ext + CMP_W'(1);
   assign row_inc     = cur_row + 16'd1;
   assign cur_emit    = (cur_row >= 16'd2) && (cur_col_ext >= CMP_W'(2));
   assign cur_last    = (cur_row == eff_h - 16'd1) && (cur_col_ext == eff_w - CMP_W'(1));

   assign advance       = !mag_valid || rsp_bus.ready;
   assign req_bus.ready = advance && !reset;
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_inc >= eff_w) begin
            col_in = '0;
            row_in = (row_inc >= eff_h) ? '0 : row_inc;
         end else begin
            col_in = col_inc[COL_W-1:0];
            row_in = cur_row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // stage 1 registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_pix_ff  <= req_bus.pixel_value;
         s1_col_ff  <= cur_col;
         s1_row_ff  <= cur_row;
         s1_emit_ff <= cur_emit;
         s1_last_ff <= cur_last;
      end
   end

   // line stores, packed as {upper, middle}; read into line_rd_ff, written back from the stage 1 registers
   always_ff @(posedge clock) begin
      if (advance) begin
         line_rd_ff <= line_mem[cur_col];
         if (s1_valid_ff) begin
            line_mem[s1_col_ff] <= {line_rd_ff[PIXEL_W-1:0], s1_pix_ff};
         end
      end
   end

   // window: three column cells, newest on the right
   assign shift_en          = advance && s1_valid_ff;
   assign col_chain[3].top  = line_rd_ff[2*PIXEL_W-1:PIXEL_W];
   assign col_chain[3].mid  = line_rd_ff[PIXEL_W-1:0];
   assign col_chain[3].bot  = s1_pix_ff;

   for (genvar k = 0; k < 3; k++) begin : g_cell
      sobthr_col_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .col_in   (col_chain[k+1]),
         .col_out  (col_chain[k]),
         .col_sum  (col_sum[k]),
         .col_diff (col_diff[k])
      );
   end

   assign s2_meta_in.row  = s1_row_ff - 16'd1;
   assign s2_meta_in.col  = COL_OUT_W'(s1_col_ff - COL_W'(1));
   assign s2_meta_in.last = s1_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff && s1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_meta_ff <= s2_meta_in;
      end
   end

   sobthr_mag u_mag (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s2_valid_ff),
      .in_meta   (s2_meta_ff),
      .col_sum   (col_sum),
      .col_diff  (col_diff),
      .threshold (thr_ff),
      .out_valid (mag_valid),
      .out_edge  (mag_edge),
      .out_meta  (mag_meta)
   );

   assign rsp_bus.valid      = mag_valid;
   assign rsp_bus.edge_value = mag_edge;
   assign rsp_bus.out_row    = mag_meta.row;
   assign rsp_bus.out_col    = mag_meta.col;
   assign rsp_bus.frame_last = mag_meta.last;

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      accept |=> (CMP_W'(col_ff) < $past(eff_w)))
      else $error("column counter left the frame width");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(s1_col_ff) && $stable(s1_valid_ff) && $stable(s2_valid_ff))
      else $error("pipeline moved during a stall");

   a_last_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.frame_last) |-> (rsp_bus.out_row == eff_h - 16'd2))
      else $error("frame end marked off the last interior row");

   a_no_border_row: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (s2_meta_ff.row != '0))
      else $error("result issued for the top border row");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_edge_threshold_top testbench
// drives pixel frames, register writes and response stalls into the block,
// predicts every edge result in an independent sobel model and checks each
// response transfer in order against the oldest predicted result
// ----------------------------------------------------------------------------
module tb;
   import sobthr_pkg::*;

   localparam int LINE_MAX      = 1024;
   localparam int SETTLE_CYCLES = 12;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int MAX_REPORTS   = 40;
   localparam int TIMEOUT_NS    = 8_000_000;
   localparam int RANDOM_ITEMS  = 450;

   localparam logic [CSR_IDX_W-1:0] REG_INDEX_UNUSED = 2'd3;
   localparam logic [THR_W-1:0]     THR_MAX          = 11'd2047;

   typedef enum int {PIX_NOISE, PIX_SMOOTH, PIX_EXTREME} pixel_mode_type;

   typedef struct {
      pixel_type            edge_value;
      logic [ROW_W-1:0]     out_row;
      logic [COL_OUT_W-1:0] out_col;
      logic                 frame_last;
   } edge_result_type;

   logic clock;
   logic reset;

   sobthr_req_if req_bus ();
   sobthr_rsp_if rsp_bus ();
   sobthr_csr_if csr_bus ();

   sobel_edge_threshold_top #(.MAX_WIDTH(LINE_MAX)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // predicted sobel state
   pixel_type        line_upper  [LINE_MAX];
   pixel_type        line_middle [LINE_MAX];
   pixel_type        window_px   [9];
   int unsigned      next_col;
   int unsigned      next_row;
   logic [THR_W-1:0]   cfg_threshold;
   logic [IMG_W_W-1:0] cfg_width;
   logic [ROW_W-1:0]   cfg_height;

   edge_result_type pending_edges [$];

   int err_count;
   int pixels_accepted;
   int results_checked;
   int edges_seen;
   int reg_writes;

   bit             src_idle_en;
   bit             snk_idle_en;
   int             hold_request;
   pixel_mode_type pixel_mode;
   int             base_level;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("[sobel_edge_threshold_top] ERROR");
      $finish;
   end

   function automatic int unsigned clamp_width(input int unsigned w);
      if (w < MIN_DIM) return MIN_DIM;
      if (w > LINE_MAX) return LINE_MAX;
      return w;
   endfunction

   function automatic int unsigned clamp_height(input int unsigned h);
      if (h < MIN_DIM) return MIN_DIM;
      return h;
   endfunction

   function automatic void sobel_reset();
      foreach (line_upper[i]) begin
         line_upper[i]  = '0;
         line_middle[i] = '0;
      end
      foreach (window_px[i]) window_px[i] = '0;
      next_col      = 0;
      next_row      = 0;
      cfg_threshold = THR_RESET;
      cfg_width     = WIDTH_RESET;
      cfg_height    = HEIGHT_RESET;
   endfunction

   function automatic void apply_reg_write(input logic [CSR_IDX_W-1:0] idx,
                                           input logic [CSR_DATA_W-1:0] data);
      case (idx)
         REG_EDGE_THRESHOLD: cfg_threshold = data[THR_W-1:0];
         REG_IMAGE_WIDTH:    cfg_width     = data[IMG_W_W-1:0];
         REG_IMAGE_HEIGHT:   cfg_height    = data[ROW_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic void sobel_predict(input pixel_type px);
      int unsigned     w, h, c, r;
      int              gx, gy, mag, thr2;
      pixel_type       top_px, mid_px;
      edge_result_type res;
      w = clamp_width(cfg_width);
      h = clamp_height(cfg_height);
      if (next_col >= w) begin
         next_col = 0;
         next_row = (next_row + 1) & 16'hFFFF;
      end
      if (next_row >= h) next_row = 0;
      c = next_col;
      r = next_row;
      top_px = line_upper[c];
      mid_px = line_middle[c];
      line_upper[c]  = mid_px;
      line_middle[c] = px;
      for (int k = 0; k < 3; k++) begin
         window_px[k*3]   = window_px[k*3+1];
         window_px[k*3+1] = window_px[k*3+2];
      end
      window_px[2] = top_px;
      window_px[5] = mid_px;
      window_px[8] = px;
      if (r >= 2 && c >= 2) begin
         gx = (int'(window_px[0]) + 2*int'(window_px[3]) + int'(window_px[6]))
            - (int'(window_px[2]) + 2*int'(window_px[5]) + int'(window_px[8]));
         gy = (int'(window_px[0]) + 2*int'(window_px[1]) + int'(window_px[2]))
            - (int'(window_px[6]) + 2*int'(window_px[7]) + int'(window_px[8]));
         mag  = gx*gx + gy*gy;
         thr2 = int'(cfg_threshold) * int'(cfg_threshold);
         res.edge_value = (mag > thr2) ? EDGE_ON : EDGE_OFF;
         res.out_row    = ROW_W'(r - 1);
         res.out_col    = COL_OUT_W'(c - 1);
         res.frame_last = (r == h - 1 && c == w - 1);
         pending_edges.push_back(res);
      end
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      next_col = c;
      next_row = r & 16'hFFFF;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      err_count++;
      if (err_count <= MAX_REPORTS)
         $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
   endtask

   task automatic check_edge_result();
      edge_result_type want;
      string           where;
      if (pending_edges.size() == 0) begin
         report_mismatch("response with no result pending, col", rsp_bus.out_col, -1);
         return;
      end
      want = pending_edges.pop_front();
      results_checked++;
      if (want.edge_value == EDGE_ON) edges_seen++;
      where = $sformatf("row %0d col %0d", want.out_row, want.out_col);
      if (rsp_bus.edge_value !== want.edge_value)
         report_mismatch({"edge_value ", where}, rsp_bus.edge_value, want.edge_value);
      if (rsp_bus.out_row !== want.out_row)
         report_mismatch({"out_row ", where}, rsp_bus.out_row, want.out_row);
      if (rsp_bus.out_col !== want.out_col)
         report_mismatch({"out_col ", where}, rsp_bus.out_col, want.out_col);
      if (rsp_bus.frame_last !== want.frame_last)
         report_mismatch({"frame_last ", where}, rsp_bus.frame_last, want.frame_last);
   endtask

   // transfer monitor for all three channels
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_bus.valid === 1'b1 && csr_bus.ready === 1'b1) begin
            apply_reg_write(csr_bus.index, csr_bus.data);
            reg_writes++;
         end
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
            sobel_predict(req_bus.pixel_value);
            pixels_accepted++;
         end
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) check_edge_result();
      end
   end

   // response side stalls
   initial begin
      int stall_left;
      stall_left    = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            stall_left   = hold_request;
            hold_request = 0;
         end
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else if (snk_idle_en && $urandom_range(0, 4) == 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left = $urandom_range(0, 3);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   function automatic pixel_type next_pixel();
      int v;
      case (pixel_mode)
         PIX_NOISE:   return pixel_type'($urandom_range(0, 255));
         PIX_EXTREME: return ($urandom_range(0, 1) == 1) ? 8'd255 : 8'd0;
         default: begin
            if ($urandom_range(0, 15) == 0) base_level = $urandom_range(0, 255);
            v = base_level + int'($urandom_range(0, 24)) - 12;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            return pixel_type'(v);
         end
      endcase
   endfunction

   task automatic send_pixel(input pixel_type px);
      int gap;
      gap = (src_idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.pixel_value <= px;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
   endtask

   task automatic send_frame(input int unsigned w, input int unsigned h);
      repeat (w * h) send_pixel(next_pixel());
   endtask

   // 3x3 frame, first pixel in the top byte
   task automatic send_patch(input logic [9*PIXEL_W-1:0] patch);
      for (int i = 0; i < 9; i++) send_pixel(patch[(8-i)*PIXEL_W +: PIXEL_W]);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic write_geometry(input logic [CSR_DATA_W-1:0] thr,
                                 input logic [CSR_DATA_W-1:0] w,
                                 input logic [CSR_DATA_W-1:0] h);
      write_reg(REG_EDGE_THRESHOLD, thr);
      write_reg(REG_IMAGE_WIDTH, w);
      write_reg(REG_IMAGE_HEIGHT, h);
   endtask

   task automatic wait_idle();
      int waited;
      @(negedge clock);
      req_bus.valid <= 1'b0;
      waited = 0;
      while (pending_edges.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_edges.size() != 0) begin
         report_mismatch("results never returned, count", 0, pending_edges.size());
         pending_edges.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // reset threshold and height on a narrow frame
   task automatic test_reset_defaults();
      src_idle_en = 1'b1;
      snk_idle_en = 1'b1;
      pixel_mode  = PIX_SMOOTH;
      write_reg(REG_IMAGE_WIDTH, 16'd8);
      send_frame(8, 4);
      wait_idle();
   endtask

   // magnitude exactly at the threshold is not an edge
   task automatic test_threshold_boundary();
      wait_idle();
      write_geometry(16'd1020, 16'd3, 16'd3);
      send_patch({8'd255, 8'd77, 8'd0, 8'd255, 8'd13, 8'd0, 8'd255, 8'd77, 8'd0});
      wait_idle();
      write_reg(REG_EDGE_THRESHOLD, 16'd1019);
      send_patch({8'd255, 8'd77, 8'd0, 8'd255, 8'd13, 8'd0, 8'd255, 8'd77, 8'd0});
   endtask

   // negative gradient, a flat frame, zero and full thresholds
   task automatic test_sign_and_flat();
      wait_idle();
      write_geometry(16'd0, 16'd3, 16'd3);
      send_patch({8'd0, 8'd0, 8'd0, 8'd128, 8'd64, 8'd32, 8'd255, 8'd255, 8'd255});
      send_patch({9{8'd0}});
      wait_idle();
      write_reg(REG_EDGE_THRESHOLD, {5'h1F, THR_MAX});
      send_patch({8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255});
   endtask

   // widths and heights below the minimum, unused register index
   task automatic test_clamped_geometry();
      pixel_mode = PIX_NOISE;
      wait_idle();
      write_geometry(16'd60, 16'hF802, 16'd0);
      write_reg(REG_INDEX_UNUSED, 16'($urandom));
      send_frame(3, 3);
      wait_idle();
      write_geometry(16'd40, 16'd1, 16'd2);
      send_frame(3, 3);
      wait_idle();
      write_geometry(16'd100, 16'd0, 16'd1);
      write_reg(REG_INDEX_UNUSED, 16'hFFFF);
      send_frame(3, 3);
   endtask

   // shrink width and height while a frame is in flight
   task automatic test_midframe_geometry();
      pixel_mode = PIX_SMOOTH;
      wait_idle();
      write_geometry(16'd30, 16'd6, 16'hFFFF);
      repeat (7 * 6 + 5) send_pixel(next_pixel());
      wait_idle();
      write_reg(REG_IMAGE_WIDTH, 16'd4);
      send_frame(4, 4);
      wait_idle();
      write_reg(REG_IMAGE_HEIGHT, 16'd3);
      send_frame(4, 3);
   endtask

   // long response hold with the source still offering, then a full drain
   task automatic test_backpressure();
      wait_idle();
      write_geometry(16'd90, 16'd8, 16'd5);
      pixel_mode   = PIX_NOISE;
      src_idle_en  = 1'b0;
      hold_request = 64;
      send_frame(8, 5);
      send_frame(8, 5);
      wait_idle();
      src_idle_en  = 1'b1;
      hold_request = 40;
      send_frame(8, 5);
   endtask

   task automatic test_random_frames(input int target);
      int               sent, frames;
      int unsigned      w, h;
      logic [THR_W-1:0] thr;
      sent = 0;
      while (sent < target) begin
         wait_idle();
         case ($urandom_range(0, 5))
            0:       thr = '0;
            1:       thr = THR_MAX;
            2:       thr = THR_W'($urandom);
            default: thr = THR_W'($urandom_range(16, 260));
         endcase
         w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
         h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
         write_geometry({5'($urandom), thr}, {5'($urandom), 11'(w)}, 16'(h));
         if ($urandom_range(0, 5) == 0) write_reg(REG_INDEX_UNUSED, 16'($urandom));
         pixel_mode  = pixel_mode_type'($urandom_range(0, 2));
         src_idle_en = (sent < target * 3 / 4) && ($urandom_range(0, 3) != 0);
         snk_idle_en = (sent < target * 3 / 4) && ($urandom_range(0, 3) != 0);
         frames = $urandom_range(1, 3);
         repeat (frames) send_frame(clamp_width(w), clamp_height(h));
         sent += frames * clamp_width(w) * clamp_height(h);
      end
   endtask

   initial begin
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.pixel_value = '0;
      csr_bus.valid       = 1'b0;
      csr_bus.index       = '0;
      csr_bus.data        = '0;
      src_idle_en         = 1'b0;
      snk_idle_en         = 1'b0;
      hold_request        = 0;
      pixel_mode          = PIX_NOISE;
      base_level          = 128;
      err_count           = 0;
      pixels_accepted     = 0;
      results_checked     = 0;
      edges_seen          = 0;
      reg_writes          = 0;
      sobel_reset();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_threshold_boundary();
      test_sign_and_flat();
      test_clamped_geometry();
      test_midframe_geometry();
      test_backpressure();
      test_random_frames(RANDOM_ITEMS);
      wait_idle();

      $display("run covered %0d pixel transfers, %0d checked results (%0d edges)",
               pixels_accepted, results_checked, edges_seen);
      $display("and %0d register writes over default, clamped and mid-frame geometries",
               reg_writes);
      if (err_count == 0) begin
         $display("[sobel_edge_threshold_top] OK");
      end else begin
         $display("[sobel_edge_threshold_top] ERROR");
      end
      $finish;
   end

endmodule
